[design/ctok_pkg.sv]
// Shared types and constants of the configuration line tokenizer.
`default_nettype none

package ctok_pkg;

  // Field widths of the input and result words.
  localparam int CHAR_W  = 8;
  localparam int KIND_W  = 2;
  localparam int COUNT_W = 7;
  localparam int STAT_W  = 3;

  // Defaults for the top-level parameters, the register reset value and the count saturation value.
  localparam int MAX_TOKEN_LEN_DEF = 256;
  localparam int QUEUE_DEPTH_DEF   = 4;
  localparam logic [COUNT_W-1:0] MAX_TOKENS_RST = 7'd16;
  localparam logic [COUNT_W-1:0] COUNT_SAT      = 7'd127;

  // Characters with a special meaning.
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_BSL   = 8'h5C;
  localparam logic [CHAR_W-1:0] CH_DQ    = 8'h22;
  localparam logic [CHAR_W-1:0] CH_SQ    = 8'h27;
  localparam logic [CHAR_W-1:0] CH_SEMI  = 8'h3B;
  localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;

  // Parser position within the line.
  typedef enum logic [1:0] {
    MODE_INIT = 2'd0,
    MODE_DQ   = 2'd1,
    MODE_UQ   = 2'd2,
    MODE_SQ   = 2'd3
  } mode_t;

  // Kind of a result word.
  typedef enum logic [KIND_W-1:0] {
    KIND_CHAR = 2'd0,
    KIND_END  = 2'd1,
    KIND_LINE = 2'd2
  } kind_t;

  // Line status reported with a line-done word.
  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_OPEN_DQ   = 3'd1,
    ST_OPEN_SQ   = 3'd2,
    ST_BAD_ESC   = 3'd3,
    ST_TOO_LONG  = 3'd4,
    ST_TRAIL_ESC = 3'd5
  } status_t;

  // A classified character as it travels from the front to the back.
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              is_zero;
    logic              is_ws;
    logic              is_bsl;
    logic              is_dq;
    logic              is_sq;
    logic              is_cmt;
  } char_word_t;

endpackage

`default_nettype wire

[design/config_line_tokenizer.sv]
// Top level of the configuration line tokenizer.
// Splits text lines, one character per word, into shell-style tokens and
// emits token characters, token ends and one line-done word per line. It
// takes one character per clock cycle as long as results are drained; a
// character passes through the classifier queue and then the parser's
// output register on its way to the result ports. The queue (QUEUE_DEPTH
// words) lets the input keep flowing while the result side is stalled.
// The user must write max_tokens through cfg_wr_en/cfg_wr_data only while
// the block is idle; the block itself does not enforce this.
`default_nettype none

module config_line_tokenizer #(
  parameter int MAX_TOKEN_LEN = ctok_pkg::MAX_TOKEN_LEN_DEF,
  parameter int QUEUE_DEPTH   = ctok_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_wr_en,
  input  wire logic [ctok_pkg::COUNT_W-1:0]       cfg_wr_data,
  input  wire logic                               push,
  output logic                                    full,
  input  wire logic [ctok_pkg::CHAR_W-1:0]        in_ch,
  output logic                                    empty,
  input  wire logic                               pop,
  output logic [ctok_pkg::KIND_W-1:0]             out_kind,
  output logic [ctok_pkg::CHAR_W-1:0]             out_token_char,
  output logic [ctok_pkg::COUNT_W-1:0]            out_token_count,
  output logic [ctok_pkg::STAT_W-1:0]             out_status
);

  logic [ctok_pkg::COUNT_W-1:0] max_tokens_r;
  ctok_pkg::char_word_t         in_word;
  ctok_pkg::char_word_t         q_word;
  logic                         q_valid;
  logic                         q_rd;

  // Token limit register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_tokens_r <= ctok_pkg::MAX_TOKENS_RST;
    end else if (cfg_wr_en) begin
      max_tokens_r <= cfg_wr_data;
    end
  end

  ctok_front u_front (
    .ch   (in_ch),
    .word (in_word)
  );

  ctok_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (push),
    .wr_data  (in_word),
    .full     (full),
    .rd_en    (q_rd),
    .rd_data  (q_word),
    .rd_valid (q_valid)
  );

  ctok_back #(
    .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .max_tokens      (max_tokens_r),
    .q_valid         (q_valid),
    .q_word          (q_word),
    .q_rd            (q_rd),
    .empty           (empty),
    .pop             (pop),
    .out_kind        (out_kind),
    .out_token_char  (out_token_char),
    .out_token_count (out_token_count),
    .out_status      (out_status)
  );

endmodule

`default_nettype wire

[design/ctok_front.sv]
// Front end: classifies each accepted character for the parser.
`default_nettype none

module ctok_front (
  input  wire logic [ctok_pkg::CHAR_W-1:0] ch,
  output ctok_pkg::char_word_t             word
);

  // Character class flags; byte 0 counts as whitespace.
  always_comb begin
    word.ch      = ch;
    word.is_zero = (ch == ctok_pkg::CH_NUL);
    word.is_ws   = (ch == ctok_pkg::CH_NUL) || (ch == ctok_pkg::CH_SPACE) ||
                   ((ch >= ctok_pkg::CH_TAB) && (ch <= ctok_pkg::CH_CR));
    word.is_bsl  = (ch == ctok_pkg::CH_BSL);
    word.is_dq   = (ch == ctok_pkg::CH_DQ);
    word.is_sq   = (ch == ctok_pkg::CH_SQ);
    word.is_cmt  = (ch == ctok_pkg::CH_SEMI) || (ch == ctok_pkg::CH_HASH);
  end

endmodule

`default_nettype wire

[design/ctok_queue.sv]
// Short queue of classified characters between the front and the parser.
`default_nettype none

module ctok_queue #(
  parameter int DEPTH = ctok_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 wr_en,
  input  wire ctok_pkg::char_word_t wr_data,
  output logic                      full,
  input  wire logic                 rd_en,
  output ctok_pkg::char_word_t      rd_data,
  output logic                      rd_valid
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ctok_pkg::char_word_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;
  assign rd_data  = mem[rd_ptr_r];

  // Pointer wrap and fill level.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

[design/ctok_back.sv]
// Back end: the tokenizer state machine and the result output register.
`default_nettype none

module ctok_back #(
  parameter int MAX_TOKEN_LEN = ctok_pkg::MAX_TOKEN_LEN_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic [ctok_pkg::COUNT_W-1:0]       max_tokens,
  input  wire logic                               q_valid,
  input  wire ctok_pkg::char_word_t               q_word,
  output logic                                    q_rd,
  output logic                                    empty,
  input  wire logic                               pop,
  output logic [ctok_pkg::KIND_W-1:0]             out_kind,
  output logic [ctok_pkg::CHAR_W-1:0]             out_token_char,
  output logic [ctok_pkg::COUNT_W-1:0]            out_token_count,
  output logic [ctok_pkg::STAT_W-1:0]             out_status
);

  localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1);

  // Parser state.
  ctok_pkg::mode_t               mode_r, mode_nxt;
  logic                          esc_r, esc_nxt;
  logic [LEN_W-1:0]              len_r, len_nxt;
  logic [ctok_pkg::COUNT_W-1:0]  cnt_r, cnt_nxt;
  logic                          skip_r, skip_nxt;

  // Output register.
  logic                          ov_r, ov_nxt;
  ctok_pkg::kind_t               okind_r, okind_nxt;
  logic [ctok_pkg::CHAR_W-1:0]   ochar_r, ochar_nxt;
  logic [ctok_pkg::COUNT_W-1:0]  ocnt_r, ocnt_nxt;
  ctok_pkg::status_t             ost_r, ost_nxt;

  // Decode of the current character.
  logic                          fire;
  logic                          parse;
  ctok_pkg::mode_t               mode_sw;
  logic                          done;
  logic                          emit;
  logic                          cmt;
  logic                          line_end;
  ctok_pkg::status_t             line_st;
  logic [ctok_pkg::COUNT_W-1:0]  cnt_inc;
  logic [ctok_pkg::COUNT_W-1:0]  limit;

  // A character is taken from the queue when the output register is free or being emptied.
  assign fire  = q_valid && (!ov_r || pop);
  assign q_rd  = fire;
  assign empty = !ov_r;
  assign limit = (max_tokens == '0) ? ctok_pkg::COUNT_W'(1) : max_tokens;

  // Classify the character against the current mode and find a line end.
  always_comb begin
    parse    = 1'b0;
    mode_sw  = mode_r;
    done     = 1'b0;
    emit     = 1'b0;
    cmt      = 1'b0;
    line_end = 1'b0;
    line_st  = ctok_pkg::ST_OK;
    if (!skip_r && !(!esc_r && q_word.is_bsl && (mode_r != ctok_pkg::MODE_SQ))) begin
      parse = 1'b1;
      case (mode_r)
        ctok_pkg::MODE_INIT: begin
          if (!q_word.is_ws) begin
            if (q_word.is_cmt) begin
              cmt = 1'b1;
            end else if (!esc_r && q_word.is_dq) begin
              mode_sw = ctok_pkg::MODE_DQ;
            end else if (!esc_r && q_word.is_sq) begin
              mode_sw = ctok_pkg::MODE_SQ;
            end else begin
              emit    = 1'b1;
              mode_sw = ctok_pkg::MODE_UQ;
            end
          end
        end
        ctok_pkg::MODE_UQ: begin
          if (!esc_r && q_word.is_ws) begin
            done = 1'b1;
          end else begin
            emit = !q_word.is_zero;
          end
        end
        ctok_pkg::MODE_DQ: begin
          if (!esc_r && q_word.is_dq) begin
            done = 1'b1;
          end else begin
            emit = !q_word.is_zero;
          end
        end
        ctok_pkg::MODE_SQ: begin
          if (q_word.is_sq) begin
            done = 1'b1;
          end else begin
            emit = !q_word.is_zero;
          end
        end
        default: begin
          mode_sw = ctok_pkg::MODE_INIT;
        end
      endcase
      if (done) begin
        mode_sw = ctok_pkg::MODE_INIT;
      end
    end

    cnt_inc = (done && (cnt_r != ctok_pkg::COUNT_SAT)) ?
              cnt_r + ctok_pkg::COUNT_W'(1) : cnt_r;

    // Line-ending causes in priority order.
    if (parse) begin
      if (cmt) begin
        line_end = 1'b1;
      end else if (esc_r && emit && !(q_word.is_bsl || q_word.is_dq || q_word.is_ws)) begin
        line_end = 1'b1;
        line_st  = ctok_pkg::ST_BAD_ESC;
      end else if (emit && (len_r >= LEN_W'(MAX_TOKEN_LEN))) begin
        line_end = 1'b1;
        line_st  = ctok_pkg::ST_TOO_LONG;
      end else if (done && (cnt_inc >= limit)) begin
        line_end = 1'b1;
      end else if (q_word.is_zero) begin
        line_end = 1'b1;
        case (mode_sw)
          ctok_pkg::MODE_DQ: line_st = ctok_pkg::ST_OPEN_DQ;
          ctok_pkg::MODE_SQ: line_st = ctok_pkg::ST_OPEN_SQ;
          ctok_pkg::MODE_UQ: line_st = ctok_pkg::ST_TRAIL_ESC;
          default:           line_st = ctok_pkg::ST_OK;
        endcase
      end
    end
  end

  // Next parser state.
  always_comb begin
    mode_nxt = mode_r;
    esc_nxt  = esc_r;
    len_nxt  = len_r;
    cnt_nxt  = cnt_r;
    skip_nxt = skip_r;
    if (fire) begin
      if (skip_r) begin
        if (q_word.is_zero) begin
          skip_nxt = 1'b0;
        end
      end else if (!parse) begin
        esc_nxt = 1'b1;
      end else if (line_end) begin
        mode_nxt = ctok_pkg::MODE_INIT;
        esc_nxt  = 1'b0;
        len_nxt  = '0;
        cnt_nxt  = '0;
        skip_nxt = !q_word.is_zero;
      end else begin
        esc_nxt  = 1'b0;
        mode_nxt = mode_sw;
        cnt_nxt  = cnt_inc;
        if (done) begin
          len_nxt = '0;
        end else if (emit) begin
          len_nxt = len_r + LEN_W'(1);
        end
      end
    end
  end

  // Result word into the output register.
  always_comb begin
    ov_nxt    = ov_r;
    okind_nxt = okind_r;
    ochar_nxt = ochar_r;
    ocnt_nxt  = ocnt_r;
    ost_nxt   = ost_r;
    if (pop && ov_r) begin
      ov_nxt = 1'b0;
    end
    if (fire && parse) begin
      ochar_nxt = '0;
      ocnt_nxt  = '0;
      ost_nxt   = ctok_pkg::ST_OK;
      if (line_end) begin
        ov_nxt    = 1'b1;
        okind_nxt = ctok_pkg::KIND_LINE;
        ocnt_nxt  = (line_st == ctok_pkg::ST_OK) ? cnt_inc : '0;
        ost_nxt   = line_st;
      end else if (done) begin
        ov_nxt    = 1'b1;
        okind_nxt = ctok_pkg::KIND_END;
      end else if (emit) begin
        ov_nxt    = 1'b1;
        okind_nxt = ctok_pkg::KIND_CHAR;
        ochar_nxt = q_word.ch;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= ctok_pkg::MODE_INIT;
      esc_r  <= 1'b0;
      len_r  <= '0;
      cnt_r  <= '0;
      skip_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      esc_r  <= esc_nxt;
      len_r  <= len_nxt;
      cnt_r  <= cnt_nxt;
      skip_r <= skip_nxt;
      ov_r   <= ov_nxt;
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk) begin
    okind_r <= okind_nxt;
    ochar_r <= ochar_nxt;
    ocnt_r  <= ocnt_nxt;
    ost_r   <= ost_nxt;
  end

  assign out_kind        = okind_r;
  assign out_token_char  = ochar_r;
  assign out_token_count = ocnt_r;
  assign out_status      = ost_r;

endmodule

`default_nettype wire
